>>> hw/rtl/assert_macros.svh
// Assertion macros used by the bound checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define SAST_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, ignored while reset is high.
`define SAST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> hw/rtl/sast_pkg.sv
package sast_pkg;

   localparam int CAPACITY = 1024;
   localparam int MAX_LIST = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = IDX_W + 1;
   localparam int ADDR_W   = 16;
   localparam int KIND_W   = 2;
   localparam int ORD_W    = 10;
   localparam int MAXL_W   = 5;
   localparam int MCNT_W   = 11;
   localparam int N_W      = $clog2(MAX_LIST + 1);

   localparam logic [KIND_W-1:0] KIND_OTHER = 2'd0;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_LOOKUP = 2'd1,
      ACT_LIST   = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [KIND_W-1:0] kind;
      logic [ORD_W-1:0]  ord;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {RD_MID, RD_SHIFT, RD_FIRST, RD_WALK} rd_sel_type;
   typedef enum logic {WR_SHIFT, WR_NEW} wr_sel_type;
   typedef enum logic [2:0] {
      OUT_ZERO, OUT_FULL, OUT_INSERT, OUT_LOOKUP, OUT_PEND, OUT_LIST_END
   } out_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SR_ISSUE, ST_SR_CMP, ST_SH_ISSUE, ST_SH_WR, ST_INS_WR,
      ST_LK_OUT, ST_WK_ISSUE, ST_WK_CHK, ST_WK_DONE, ST_CLEAR, ST_FULL
   } state_type;

   typedef struct packed {
      logic        req_load;
      logic        srch_init;
      logic        srch_step;
      logic        save_first;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        shift_init;
      logic        shift_dec;
      logic        walk_init;
      logic        walk_step;
      logic        wr_en;
      wr_sel_type  wr_sel;
      logic        count_inc;
      logic        count_clr;
      logic        out_load;
      out_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       full;
      logic       srch_more;
      logic       srch_upper;
      logic       shift_more;
      logic       walk_more;
      logic       walk_hit;
      logic       walk_emit;
      logic       lk_hit;
      logic       out_free;
   } stat_type;

   function automatic logic [MCNT_W-1:0] sat_count(input logic [CNT_W-1:0] x);
      logic [MCNT_W-1:0] r;
      if (CNT_W > MCNT_W && x > CNT_W'({MCNT_W{1'b1}})) begin
         r = {MCNT_W{1'b1}};
      end else begin
         r = MCNT_W'(x);
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/sast_ram.sv
module sast_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/sast_ctrl.sv
module sast_ctrl import sast_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_action,
   output logic       req_stall,
   input  stat_type   stat,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   action_type req_act;

   assign req_act = action_type'(req_action);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_act == ACT_CLEAR) begin
                  state_in = ST_CLEAR;
               end else if (req_act == ACT_INSERT && stat.full) begin
                  state_in = ST_FULL;
               end else begin
                  state_in = ST_SR_ISSUE;
               end
            end
         end
         ST_SR_ISSUE: begin
            if (stat.srch_more) begin
               state_in = ST_SR_CMP;
            end else begin
               unique case (stat.action)
                  ACT_INSERT: state_in = ST_SH_ISSUE;
                  ACT_LIST:   state_in = ST_WK_ISSUE;
                  ACT_LOOKUP: state_in = stat.srch_upper ? ST_LK_OUT : ST_SR_ISSUE;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_SR_CMP:   state_in = ST_SR_ISSUE;
         ST_SH_ISSUE: state_in = stat.shift_more ? ST_SH_WR : ST_INS_WR;
         ST_SH_WR:    state_in = ST_SH_ISSUE;
         ST_INS_WR:   if (stat.out_free) state_in = ST_IDLE;
         ST_LK_OUT:   if (stat.out_free) state_in = ST_IDLE;
         ST_WK_ISSUE: state_in = stat.walk_more ? ST_WK_CHK : ST_WK_DONE;
         ST_WK_CHK: begin
            if (!stat.walk_hit) begin
               state_in = ST_WK_DONE;
            end else if (!(stat.walk_emit && !stat.out_free)) begin
               state_in = ST_WK_ISSUE;
            end
         end
         ST_WK_DONE:  if (stat.out_free) state_in = ST_IDLE;
         ST_CLEAR:    if (stat.out_free) state_in = ST_IDLE;
         ST_FULL:     if (stat.out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.rd_sel  = RD_MID;
      cmd.wr_sel  = WR_SHIFT;
      cmd.out_sel = OUT_ZERO;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: cmd.req_load = req_valid;
         ST_SR_ISSUE: begin
            if (stat.srch_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_MID;
            end else begin
               unique case (stat.action)
                  ACT_INSERT: cmd.shift_init = 1'b1;
                  ACT_LIST:   cmd.walk_init  = 1'b1;
                  ACT_LOOKUP: begin
                     if (!stat.srch_upper) begin
                        cmd.save_first = 1'b1;
                        cmd.srch_init  = 1'b1;
                     end else begin
                        cmd.rd_en  = stat.lk_hit;
                        cmd.rd_sel = RD_FIRST;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SR_CMP: cmd.srch_step = 1'b1;
         ST_SH_ISSUE: begin
            cmd.rd_en  = stat.shift_more;
            cmd.rd_sel = RD_SHIFT;
         end
         ST_SH_WR: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = WR_SHIFT;
            cmd.shift_dec = 1'b1;
         end
         ST_INS_WR: begin
            cmd.wr_en     = stat.out_free;
            cmd.wr_sel    = WR_NEW;
            cmd.count_inc = stat.out_free;
            cmd.out_load  = stat.out_free;
            cmd.out_sel   = OUT_INSERT;
         end
         ST_LK_OUT: begin
            cmd.out_load = stat.out_free;
            cmd.out_sel  = OUT_LOOKUP;
         end
         ST_WK_ISSUE: begin
            cmd.rd_en  = stat.walk_more;
            cmd.rd_sel = RD_WALK;
         end
         ST_WK_CHK: begin
            if (stat.walk_hit && !(stat.walk_emit && !stat.out_free)) begin
               cmd.walk_step = 1'b1;
               cmd.out_load  = stat.walk_emit;
               cmd.out_sel   = OUT_PEND;
            end
         end
         ST_WK_DONE: begin
            cmd.out_load = stat.out_free;
            cmd.out_sel  = OUT_LIST_END;
         end
         ST_CLEAR: begin
            cmd.count_clr = stat.out_free;
            cmd.out_load  = stat.out_free;
            cmd.out_sel   = OUT_ZERO;
         end
         ST_FULL: begin
            cmd.out_load = stat.out_free;
            cmd.out_sel  = OUT_FULL;
         end
         default: ;
      endcase
   end

endmodule

>>> hw/rtl/sast_dp.sv
module sast_dp import sast_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          req_action,
   input  logic [ADDR_W-1:0]   req_address,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [MAXL_W-1:0]   req_max_list,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_status,
   output logic                rsp_found,
   output logic                rsp_name_valid,
   output logic [ORD_W-1:0]    rsp_name_ordinal,
   output logic [KIND_W-1:0]   rsp_kind_out,
   output logic [MCNT_W-1:0]   rsp_match_count,
   output logic                rsp_last,
   input  cmd_type             cmd,
   output stat_type            stat
);

   action_type        action_ff;
   logic [ADDR_W-1:0] key_ff;
   logic [KIND_W-1:0] kind_ff;
   logic [N_W-1:0]    limit_ff, n_ff;
   logic [CNT_W-1:0]  lo_ff, hi_ff, first_ff, idx_ff, count_ff, total_ff;
   logic              upper_ff, found_ff, pend_valid_ff;
   entry_type         pend_ff;

   logic              rsp_valid_ff, status_ff, found_out_ff, nv_ff, last_ff;
   logic [ORD_W-1:0]  ord_ff;
   logic [KIND_W-1:0] kind_out_ff;
   logic [MCNT_W-1:0] mcnt_ff;

   logic [CNT_W:0]    sum;
   logic [CNT_W-1:0]  mid;
   logic [IDX_W-1:0]  rd_addr, wr_addr;
   entry_type         rd_entry, wr_entry;
   logic [ENTRY_W-1:0] rd_raw;
   logic              go_right, kind_ok, out_free;

   assign sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid = sum[CNT_W:1];
   assign rd_entry = entry_type'(rd_raw);
   assign go_right = upper_ff ? (rd_entry.addr <= key_ff) : (rd_entry.addr < key_ff);
   assign kind_ok = (kind_ff == KIND_OTHER) || (rd_entry.kind == kind_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (cmd.rd_sel)
         RD_MID:   rd_addr = mid[IDX_W-1:0];
         RD_SHIFT: rd_addr = IDX_W'(idx_ff - CNT_W'(1));
         RD_FIRST: rd_addr = first_ff[IDX_W-1:0];
         default:  rd_addr = idx_ff[IDX_W-1:0];
      endcase
      if (cmd.wr_sel == WR_NEW) begin
         wr_addr  = lo_ff[IDX_W-1:0];
         wr_entry = '{addr: key_ff, kind: kind_ff, ord: ORD_W'(count_ff)};
      end else begin
         wr_addr  = idx_ff[IDX_W-1:0];
         wr_entry = rd_entry;
      end
   end

   sast_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         action_ff <= action_type'(req_action);
         key_ff    <= req_address;
         kind_ff   <= req_kind;
         if (int'(req_max_list) < MAX_LIST) begin
            limit_ff <= N_W'(req_max_list);
         end else begin
            limit_ff <= N_W'(MAX_LIST);
         end
         lo_ff    <= '0;
         hi_ff    <= count_ff;
         upper_ff <= (action_type'(req_action) == ACT_INSERT);
      end
      if (cmd.srch_init) begin
         lo_ff    <= '0;
         hi_ff    <= count_ff;
         upper_ff <= 1'b1;
      end
      if (cmd.save_first) begin
         first_ff <= lo_ff;
      end
      if (cmd.srch_step) begin
         if (go_right) begin
            lo_ff <= mid + CNT_W'(1);
         end else begin
            hi_ff <= mid;
         end
      end
      if (cmd.shift_init) begin
         idx_ff <= count_ff;
      end
      if (cmd.shift_dec) begin
         idx_ff <= idx_ff - CNT_W'(1);
      end
      if (cmd.walk_init) begin
         idx_ff        <= lo_ff;
         total_ff      <= '0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         found_ff      <= 1'b0;
      end
      if (cmd.walk_step) begin
         idx_ff   <= idx_ff + CNT_W'(1);
         found_ff <= 1'b1;
         if (kind_ok) begin
            total_ff <= total_ff + CNT_W'(1);
            if (n_ff < limit_ff) begin
               pend_ff       <= rd_entry;
               pend_valid_ff <= 1'b1;
               n_ff          <= n_ff + N_W'(1);
            end
         end
      end
      if (cmd.out_load) begin
         status_ff    <= 1'b0;
         found_out_ff <= 1'b0;
         nv_ff        <= 1'b0;
         ord_ff       <= '0;
         kind_out_ff  <= '0;
         mcnt_ff      <= '0;
         last_ff      <= 1'b1;
         case (cmd.out_sel)
            OUT_FULL: status_ff <= 1'b1;
            OUT_INSERT: begin
               nv_ff       <= 1'b1;
               ord_ff      <= ORD_W'(count_ff);
               kind_out_ff <= kind_ff;
            end
            OUT_LOOKUP: begin
               if (lo_ff > first_ff) begin
                  found_out_ff <= 1'b1;
                  nv_ff        <= 1'b1;
                  ord_ff       <= rd_entry.ord;
                  kind_out_ff  <= rd_entry.kind;
                  mcnt_ff      <= sat_count(lo_ff - first_ff);
               end
            end
            OUT_PEND: begin
               found_out_ff <= 1'b1;
               nv_ff        <= 1'b1;
               ord_ff       <= pend_ff.ord;
               kind_out_ff  <= pend_ff.kind;
               last_ff      <= 1'b0;
            end
            OUT_LIST_END: begin
               found_out_ff <= found_ff;
               mcnt_ff      <= sat_count(total_ff);
               if (pend_valid_ff) begin
                  nv_ff       <= 1'b1;
                  ord_ff      <= pend_ff.ord;
                  kind_out_ff <= pend_ff.kind;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.count_clr) begin
            count_ff <= '0;
         end else if (cmd.count_inc) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      stat.action     = action_ff;
      stat.full       = (count_ff >= CNT_W'(CAPACITY));
      stat.srch_more  = (lo_ff < hi_ff);
      stat.srch_upper = upper_ff;
      stat.shift_more = (idx_ff > lo_ff);
      stat.walk_more  = (idx_ff < count_ff);
      stat.walk_hit   = (rd_entry.addr == key_ff);
      stat.walk_emit  = (rd_entry.addr == key_ff) && kind_ok && (n_ff < limit_ff)
                        && pend_valid_ff;
      stat.lk_hit     = (lo_ff > first_ff);
      stat.out_free   = out_free;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_found        = found_out_ff;
   assign rsp_name_valid   = nv_ff;
   assign rsp_name_ordinal = ord_ff;
   assign rsp_kind_out     = kind_out_ff;
   assign rsp_match_count  = mcnt_ff;
   assign rsp_last         = last_ff;

endmodule

>>> hw/rtl/sorted_address_symbol_table_core.sv
// Lookup: two binary searches (lower then upper bound); each probe is a RAM read state and a compare state.
// Insert: one binary search, then a shift of every entry above the slot; the shift is one RAM read
// and one RAM write per moved entry. List: search, then a read state and a check state per walked entry.
// One request is in flight at a time; a finished result may wait in the output register.
// Reset empties the table by clearing the entry count; no pass over the RAM is made.
module sorted_address_symbol_table_core import sast_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_action,
   input  logic [ADDR_W-1:0]   req_address,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [MAXL_W-1:0]   req_max_list,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_status,
   output logic                rsp_found,
   output logic                rsp_name_valid,
   output logic [ORD_W-1:0]    rsp_name_ordinal,
   output logic [KIND_W-1:0]   rsp_kind_out,
   output logic [MCNT_W-1:0]   rsp_match_count,
   output logic                rsp_last
);

   cmd_type  cmd;
   stat_type stat;

   sast_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   sast_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_action       (req_action),
      .req_address      (req_address),
      .req_kind         (req_kind),
      .req_max_list     (req_max_list),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_found        (rsp_found),
      .rsp_name_valid   (rsp_name_valid),
      .rsp_name_ordinal (rsp_name_ordinal),
      .rsp_kind_out     (rsp_kind_out),
      .rsp_match_count  (rsp_match_count),
      .rsp_last         (rsp_last),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule

>>> hw/rtl/sast_checker.sv
`include "assert_macros.svh"

module sast_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_status,
   input logic        rsp_found,
   input logic        rsp_name_valid,
   input logic [9:0]  rsp_name_ordinal,
   input logic [10:0] rsp_match_count,
   input logic        rsp_last
);

   // Every request that is taken raises req_stall, so the block is busy after it.
   `SAST_ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_valid && !req_stall, req_stall)

   // A rejected insert is always a single, final result.
   `SAST_ASSERT_IMPLY(a_full_is_last, clock, reset, rsp_valid && rsp_status, rsp_last && !rsp_name_valid)

   // Results before the last one of a list always carry a matching entry.
   `SAST_ASSERT_IMPLY(a_mid_list_entry, clock, reset, rsp_valid && !rsp_last, rsp_name_valid && rsp_found)

   // The match count is reported only on the final result.
   `SAST_ASSERT_IMPLY(a_count_on_last, clock, reset, rsp_valid && !rsp_last, rsp_match_count == 11'd0)

   `SAST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_name_ordinal) && $stable(rsp_match_count))

endmodule

bind sorted_address_symbol_table_core sast_checker u_sast_checker (.*);

>>> dv/sorted_address_symbol_table_core_checker.sv
`timescale 1ns / 1ps
module sorted_address_symbol_table_core_checker import sast_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [1:0]          req_action,
   input  logic [ADDR_W-1:0]   req_address,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [MAXL_W-1:0]   req_max_list,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic                rsp_status,
   input  logic                rsp_found,
   input  logic                rsp_name_valid,
   input  logic [ORD_W-1:0]    rsp_name_ordinal,
   input  logic [KIND_W-1:0]   rsp_kind_out,
   input  logic [MCNT_W-1:0]   rsp_match_count,
   input  logic                rsp_last,
   output int                  error_count,
   output int                  pending_count,
   output int                  result_count,
   output int                  full_count
);

   typedef struct packed {
      logic              status;
      logic              found;
      logic              name_valid;
      logic [ORD_W-1:0]  name_ordinal;
      logic [KIND_W-1:0] kind_out;
      logic [MCNT_W-1:0] match_count;
      logic              last;
   } result_type;

   entry_type  sym_table[$];
   result_type expected_results[$];

   // Index of the first entry whose address is at or above (or strictly above) addr.
   function automatic int search_slot(logic [ADDR_W-1:0] addr, bit past_equal);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = sym_table.size();
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (past_equal ? (sym_table[mid].addr <= addr) : (sym_table[mid].addr < addr))
            lo = mid + 1;
         else
            hi = mid;
      end
      return lo;
   endfunction

   function automatic logic [MCNT_W-1:0] clip_count(int n);
      return (n > 2047) ? MCNT_W'(2047) : MCNT_W'(n);
   endfunction

   task automatic predict_request(action_type act, logic [ADDR_W-1:0] addr,
                                  logic [KIND_W-1:0] kind, logic [MAXL_W-1:0] max_list);
      result_type r;
      entry_type  e;
      int first;
      int after;
      int limit;
      int total;
      int emitted;
      bit hit;
      r = '0;
      r.last = 1'b1;
      case (act)
         ACT_INSERT: begin
            if (sym_table.size() >= CAPACITY) begin
               r.status = 1'b1;
               full_count++;
            end else begin
               e.addr = addr;
               e.kind = kind;
               e.ord  = ORD_W'(sym_table.size());
               sym_table.insert(search_slot(addr, 1'b1), e);
               r.name_valid   = 1'b1;
               r.name_ordinal = e.ord;
               r.kind_out     = kind;
            end
            expected_results.push_back(r);
         end
         ACT_LOOKUP: begin
            first = search_slot(addr, 1'b0);
            after = search_slot(addr, 1'b1);
            if (first < sym_table.size() && sym_table[first].addr == addr) begin
               r.found        = 1'b1;
               r.name_valid   = 1'b1;
               r.name_ordinal = sym_table[first].ord;
               r.kind_out     = sym_table[first].kind;
               r.match_count  = clip_count(after - first);
            end
            expected_results.push_back(r);
         end
         ACT_LIST: begin
            first = search_slot(addr, 1'b0);
            limit = (max_list < MAX_LIST) ? int'(max_list) : MAX_LIST;
            hit = first < sym_table.size() && sym_table[first].addr == addr;
            total = 0;
            emitted = 0;
            for (int i = first; i < sym_table.size() && sym_table[i].addr == addr; i++) begin
               if (kind != KIND_OTHER && sym_table[i].kind != kind) continue;
               if (emitted < limit) begin
                  r = '0;
                  r.found        = hit;
                  r.name_valid   = 1'b1;
                  r.name_ordinal = sym_table[i].ord;
                  r.kind_out     = sym_table[i].kind;
                  expected_results.push_back(r);
                  emitted++;
               end
               total++;
            end
            if (emitted == 0) begin
               r = '0;
               r.found       = hit;
               r.match_count = clip_count(total);
               r.last        = 1'b1;
               expected_results.push_back(r);
            end else begin
               r = expected_results.pop_back();
               r.match_count = clip_count(total);
               r.last        = 1'b1;
               expected_results.push_back(r);
            end
         end
         default: begin
            sym_table.delete();
            expected_results.push_back(r);
         end
      endcase
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("error at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         sym_table.delete();
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected transfer, pending", 0, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_status != want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_found != want.found)
                  report_mismatch("found", rsp_found, want.found);
               if (rsp_name_valid != want.name_valid)
                  report_mismatch("name_valid", rsp_name_valid, want.name_valid);
               if (rsp_name_ordinal != want.name_ordinal)
                  report_mismatch("name_ordinal", rsp_name_ordinal, want.name_ordinal);
               if (rsp_kind_out != want.kind_out)
                  report_mismatch("kind_out", rsp_kind_out, want.kind_out);
               if (rsp_match_count != want.match_count)
                  report_mismatch("match_count", rsp_match_count, want.match_count);
               if (rsp_last != want.last)
                  report_mismatch("last", rsp_last, want.last);
            end
         end
         // Prediction after the compare, so a same-edge request cannot affect this result.
         if (req_valid && !req_stall)
            predict_request(action_type'(req_action), req_address, req_kind, req_max_list);
      end
      pending_count = expected_results.size();
   end

   initial begin
      error_count = 0;
      pending_count = 0;
      result_count = 0;
      full_count = 0;
   end

endmodule

>>> dv/sorted_address_symbol_table_core_tb.sv
`timescale 1ns / 1ps
module sorted_address_symbol_table_core_tb import sast_pkg::*;;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [1:0]          req_action;
   logic [ADDR_W-1:0]   req_address;
   logic [KIND_W-1:0]   req_kind;
   logic [MAXL_W-1:0]   req_max_list;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_status;
   logic                rsp_found;
   logic                rsp_name_valid;
   logic [ORD_W-1:0]    rsp_name_ordinal;
   logic [KIND_W-1:0]   rsp_kind_out;
   logic [MCNT_W-1:0]   rsp_match_count;
   logic                rsp_last;
   int                  error_count;
   int                  pending_count;
   int                  result_count;
   int                  full_count;
   int                  cycle_count;
   int                  request_count;
   bit                  stall_enable;

   localparam int CYCLE_LIMIT = 3000000;

   sorted_address_symbol_table_core dut (.*);

   sorted_address_symbol_table_core_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("sorted_address_symbol_table_core: mismatch");
         $finish;
      end
   end

   // Result side: a random stall before each transfer while stall_enable is set.
   initial begin
      int wait_cycles;
      rsp_stall = 1'b1;
      @(posedge clock iff !reset);
      forever begin
         wait_cycles = stall_enable ? $urandom_range(6, 0) : 0;
         if (wait_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock iff rsp_valid);
      end
   end

   task automatic send_request(action_type act, logic [ADDR_W-1:0] addr,
                               logic [KIND_W-1:0] kind, logic [MAXL_W-1:0] max_list);
      int gap;
      gap = stall_enable ? $urandom_range(6, 0) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= act;
      req_address  <= addr;
      req_kind     <= kind;
      req_max_list <= max_list;
      @(posedge clock iff !req_stall);
      request_count++;
   endtask

   // Addresses come mostly from a small pool so that lookups and lists hit.
   function automatic logic [ADDR_W-1:0] pick_address();
      int sel;
      sel = $urandom_range(9, 0);
      if (sel < 7) return ADDR_W'($urandom_range(7, 0) * 16'h1111 + 16'h0f00);
      if (sel == 7) return 16'h0000;
      if (sel == 8) return 16'hffff;
      return ADDR_W'($urandom);
   endfunction

   initial begin
      int sel;
      action_type act;
      cycle_count = 0;
      request_count = 0;
      stall_enable = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_INSERT;
      req_address = '0;
      req_kind = KIND_OTHER;
      req_max_list = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-table queries, ties, filters, list limits, clear.
      send_request(ACT_LOOKUP, 16'h1234, 2'd0, 5'd0);
      send_request(ACT_LIST, 16'hffff, 2'd0, 5'd16);
      send_request(ACT_INSERT, 16'hffff, 2'd3, 5'd31);
      send_request(ACT_INSERT, 16'h0000, 2'd1, 5'd0);
      send_request(ACT_INSERT, 16'h8000, 2'd2, 5'd0);
      send_request(ACT_INSERT, 16'h8000, 2'd1, 5'd0);
      send_request(ACT_INSERT, 16'h8000, 2'd0, 5'd0);
      send_request(ACT_INSERT, 16'h7fff, 2'd3, 5'd0);
      send_request(ACT_LOOKUP, 16'h8000, 2'd3, 5'd0);
      send_request(ACT_LOOKUP, 16'h0000, 2'd0, 5'd0);
      send_request(ACT_LOOKUP, 16'h8001, 2'd0, 5'd0);
      send_request(ACT_LIST, 16'h8000, 2'd0, 5'd31);
      send_request(ACT_LIST, 16'h8000, 2'd1, 5'd16);
      send_request(ACT_LIST, 16'h8000, 2'd3, 5'd16);
      send_request(ACT_LIST, 16'h8000, 2'd0, 5'd0);
      send_request(ACT_LIST, 16'h8000, 2'd0, 5'd1);
      for (int i = 0; i < 18; i++) send_request(ACT_INSERT, 16'h5555, 2'(i), 5'd0);
      send_request(ACT_LIST, 16'h5555, 2'd0, 5'd20);
      send_request(ACT_LIST, 16'h5555, 2'd2, 5'd15);
      send_request(ACT_CLEAR, 16'haaaa, 2'd3, 5'd31);
      send_request(ACT_LOOKUP, 16'h8000, 2'd0, 5'd0);

      // Random: mostly inserts and queries on a small address pool.
      stall_enable = 1'b1;
      for (int i = 0; i < 500; i++) begin
         if (i % 100 == 50) stall_enable = ~stall_enable;
         sel = $urandom_range(99, 0);
         act = sel < 45 ? ACT_INSERT : sel < 70 ? ACT_LOOKUP : sel < 98 ? ACT_LIST : ACT_CLEAR;
         send_request(act, pick_address(), 2'($urandom), MAXL_W'($urandom_range(31, 0)));
      end

      // Fill to capacity with few distinct addresses, then probe the full case.
      stall_enable = 1'b0;
      send_request(ACT_CLEAR, 16'h0000, 2'd0, 5'd0);
      for (int i = 0; i < CAPACITY + 3; i++)
         send_request(ACT_INSERT, ADDR_W'($urandom_range(3, 0) * 16'h4000), 2'($urandom), 5'd0);
      send_request(ACT_LOOKUP, 16'h4000, 2'd0, 5'd0);
      send_request(ACT_LIST, 16'h8000, 2'd0, 5'd16);
      send_request(ACT_CLEAR, 16'h0000, 2'd0, 5'd0);
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("%0d requests and %0d result transfers, %0d table-full rejections",
               request_count, result_count, full_count);
      $display("covered insert, lookup, list with filters and limits, clear, and a full table");
      if (error_count == 0)
         $display("sorted_address_symbol_table_core: match");
      else
         $display("sorted_address_symbol_table_core: mismatch");
      $finish;
   end

endmodule
